/* sv/rational_arith_unit_defines.svh */
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rau_pkg.sv */
// Shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int Width = 32;
  localparam int CntW  = $clog2(Width + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_ZERO = 2'd1;
  localparam logic [1:0] ST_NEG_DEN   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_RED_CHK, S_GCD_TEST, S_GCD_DIV,
    S_QN_DIV, S_QD_DIV, S_DONE
  } rau_state_t;

  // Divider selects: what the shared divider is working on.
  typedef enum logic [1:0] {
    DSEL_GCD, DSEL_NUM, DSEL_DEN
  } rau_dsel_t;

  typedef struct packed {
    logic      load;      // capture the request
    logic      mul1;      // first pair of products
    logic      mul2;      // cross product and combine
    logic      red_init;  // prepare gcd operands
    logic      div_start; // launch a division
    rau_dsel_t dsel;
    logic      gcd_step;  // take the remainder into the gcd pair
    logic      qn_store;  // store the numerator quotient
    logic      q_store;   // store the denominator quotient
    logic      done;      // drive the result
  } rau_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       den_neg;
    logic       gcd_a_zero;
    logic       gcd_zero;
    logic       div_busy;
    logic       div_done;
  } rau_stat_t;
endpackage
`default_nettype wire

/* sv/rau_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_unit_defines.svh"
module rau_divider import rau_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [Width-1:0] dividend,
  input  wire logic [Width-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [Width-1:0] quot,
  output logic      [Width-1:0] rem
);
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [Width-1:0] q_r, q_nxt;
  logic [Width-1:0] r_r, r_nxt;
  logic [Width-1:0] d_r, d_nxt;
  logic [Width:0]   trial;
  logic [Width:0]   shifted;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    shifted  = {r_r, q_r[Width-1]};
    trial    = shifted - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(Width);
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (!trial[Width]) begin
        r_nxt = trial[Width-1:0];
        q_nxt = {q_r[Width-2:0], 1'b1};
      end else begin
        r_nxt = shifted[Width-1:0];
        q_nxt = {q_r[Width-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  `RAU_ASSERT_NEXT(a_div_done_ends, clk, rst_n, done_r && !start, !busy_r, "divider busy after done")
  `RAU_ASSERT_IMP(a_div_cnt, clk, rst_n, busy_r, cnt_r != '0, "divider count ran out")
  `RAU_ASSERT_IMP(a_div_excl, clk, rst_n, done_r, !busy_r, "divider done while busy")
endmodule
`default_nettype wire

/* sv/rau_datapath.sv */
// Operand registers, multipliers, gcd pair and result registers.
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath import rau_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rau_cmd_t         cmd,
  output rau_stat_t             stat,
  input  wire logic [2:0]       in_req_type,
  input  wire logic [Width-1:0] in_a_num,
  input  wire logic [Width-1:0] in_a_den,
  input  wire logic [Width-1:0] in_b_num,
  input  wire logic [Width-1:0] in_b_den,
  output logic                  out_valid,
  output logic      [Width-1:0] out_res_num,
  output logic      [Width-1:0] out_res_den,
  output logic      [1:0]       out_status
);
  logic [2:0]       op_r;
  logic [Width-1:0] an_r, ad_r, bn_r, bd_r;
  logic [Width-1:0] p0_r, p1_r;
  logic [Width-1:0] ga_r, gb_r;
  logic [Width-1:0] rn_r, rd_r;
  logic [1:0]       st_r;
  logic             valid_r;
  logic [Width-1:0] m0, m1, m2, m3;
  logic [Width-1:0] mag_an;
  logic [Width-1:0] dvd, dvs, quot, rem;
  logic             dbusy, ddone;

  assign mag_an = an_r[Width-1] ? (Width'(0) - an_r) : an_r;

  // Operands of the first pair of products; the add/subtract cross product comes later.
  always_comb begin
    case (op_r)
      OP_MUL:  begin m0 = an_r; m1 = bn_r; end
      default: begin m0 = an_r; m1 = bd_r; end
    endcase
    case (op_r)
      OP_DIV:  begin m2 = ad_r; m3 = bn_r; end
      default: begin m2 = ad_r; m3 = bd_r; end
    endcase
  end

  always_comb begin
    case (cmd.dsel)
      DSEL_NUM: begin dvd = mag_an; dvs = gb_r; end
      DSEL_DEN: begin dvd = ad_r;   dvs = gb_r; end
      default:  begin dvd = gb_r;   dvs = ga_r; end
    endcase
  end

  rau_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dvd), .divisor(dvs),
    .busy(dbusy), .done(ddone), .quot(quot), .rem(rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.done;
    end
    if (cmd.load) begin
      op_r <= in_req_type;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
      rn_r <= '0;
      rd_r <= '0;
      st_r <= ST_OK;
    end
    if (cmd.mul1) begin
      p0_r <= m0 * m1;
      p1_r <= m2 * m3;
    end
    if (cmd.mul2) begin
      case (op_r)
        OP_ADD:  rn_r <= p0_r + Width'(ad_r * bn_r);
        OP_SUB:  rn_r <= p0_r - Width'(ad_r * bn_r);
        default: rn_r <= p0_r;
      endcase
      rd_r <= p1_r;
    end
    if (cmd.red_init) begin
      ga_r <= ad_r;
      gb_r <= mag_an;
      if (ad_r[Width-1]) begin
        rn_r <= an_r;
        rd_r <= ad_r;
        st_r <= ST_NEG_DEN;
      end
    end
    if (cmd.gcd_step) begin
      gb_r <= ga_r;
      ga_r <= rem;
    end
    if (cmd.qn_store) begin
      rn_r <= an_r[Width-1] ? (Width'(0) - quot) : quot;
    end
    if (cmd.q_store) begin
      rd_r <= quot;
    end
    if (cmd.done && stat.gcd_zero && op_r == OP_RED && !ad_r[Width-1]) begin
      st_r <= ST_ZERO_ZERO;
    end
  end

  assign stat.op         = op_r;
  assign stat.den_neg    = ad_r[Width-1];
  assign stat.gcd_a_zero = (ga_r == '0);
  assign stat.gcd_zero   = (gb_r == '0);
  assign stat.div_busy   = dbusy;
  assign stat.div_done   = ddone;

  assign out_valid   = valid_r;
  assign out_res_num = rn_r;
  assign out_res_den = rd_r;
  assign out_status  = st_r;
endmodule
`default_nettype wire

/* sv/rau_ctrl.sv */
// Sequencer for the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_unit_defines.svh"
module rau_ctrl import rau_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire rau_stat_t stat,
  output rau_cmd_t       cmd
);
  rau_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (start) state_nxt = S_MUL1;
      S_MUL1:     state_nxt = (stat.op == OP_RED) ? S_RED_CHK :
                              (stat.op > OP_RED) ? S_DONE : S_MUL2;
      S_MUL2:     state_nxt = S_DONE;
      S_RED_CHK:  state_nxt = stat.den_neg ? S_DONE : S_GCD_TEST;
      S_GCD_TEST: state_nxt = stat.gcd_a_zero ? (stat.gcd_zero ? S_DONE : S_QN_DIV)
                                              : S_GCD_DIV;
      S_GCD_DIV:  if (stat.div_done) state_nxt = S_GCD_TEST;
      S_QN_DIV:   if (stat.div_done) state_nxt = S_QD_DIV;
      S_QD_DIV:   if (stat.div_done) state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.dsel = DSEL_GCD;
    case (state_r)
      S_IDLE:    cmd.load = start;
      S_MUL1:    cmd.mul1 = 1'b1;
      S_MUL2:    cmd.mul2 = 1'b1;
      S_RED_CHK: cmd.red_init = 1'b1;
      S_GCD_TEST: begin
        // Launch the next remainder, or the numerator quotient once the gcd is known.
        if (!stat.gcd_a_zero) begin
          cmd.div_start = 1'b1;
        end else if (!stat.gcd_zero) begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DSEL_NUM;
        end
      end
      S_GCD_DIV: cmd.gcd_step = stat.div_done;
      S_QN_DIV: begin
        cmd.dsel = DSEL_NUM;
        // The numerator quotient is taken in the cycle the denominator division starts.
        if (stat.div_done) begin
          cmd.qn_store  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.dsel      = DSEL_DEN;
        end
      end
      S_QD_DIV: begin
        cmd.dsel    = DSEL_DEN;
        cmd.q_store = stat.div_done;
      end
      S_DONE:  cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `RAU_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, state_r == S_IDLE && start, state_r == S_MUL1, "request not taken")
  `RAU_ASSERT_IMP(a_div_wait, clk, rst_n, (state_r == S_GCD_DIV || state_r == S_QD_DIV) && !stat.div_done, stat.div_busy, "waiting on an idle divider")
  `RAU_ASSERT_NEXT(a_done_idle, clk, rst_n, state_r == S_DONE, state_r == S_IDLE, "done not followed by idle")
endmodule
`default_nettype wire

/* sv/rational_arith_unit.sv */
// Top level of the rational arithmetic unit.
//  channel | ports                                       | handshake
//  request | in_req_type, in_a_num/den, in_b_num/den     | start & !busy
//  result  | out_res_num, out_res_den, out_status        | out_valid, one cycle
// Add, subtract, multiply and divide pass through MUL1, MUL2 and DONE before
// out_valid; unused codes skip MUL2. Reduce runs the gcd remainder loop on one
// shared restoring divider, then divides numerator and denominator unless the
// denominator is negative or both are zero. Reset is synchronous and
// returns the sequencer to idle. The receiver cannot stall: out_valid lasts
// one cycle and busy holds requests off until the result is out.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit import rau_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       in_req_type,
  input  wire logic [Width-1:0] in_a_num,
  input  wire logic [Width-1:0] in_a_den,
  input  wire logic [Width-1:0] in_b_num,
  input  wire logic [Width-1:0] in_b_den,
  output logic                  out_valid,
  output logic      [Width-1:0] out_res_num,
  output logic      [Width-1:0] out_res_den,
  output logic      [1:0]       out_status
);
  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  rau_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_req_type(in_req_type), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_status(out_status)
  );
endmodule
`default_nettype wire
